@@ rtl/tks_pkg.sv @@
// Shared definitions for the top-k score selector: list depth, widths,
// the entry and command types passed along the cell row, and state codes.
// No dependencies.
`default_nettype none

package tks_pkg;

    localparam int MAX_K   = 16;
    localparam int CNT_W   = $clog2(MAX_K + 1);
    localparam int TOPK_W  = 5;
    localparam int CMP_W   = (CNT_W > TOPK_W) ? CNT_W : TOPK_W;
    localparam int IDXV_W  = 32;
    localparam int SCORE_W = 32;
    localparam int CFG_W   = 32;

    localparam logic [TOPK_W-1:0]  TOPK_RESET   = TOPK_W'(16);
    localparam logic [SCORE_W-1:0] THRESH_RESET = {1'b1, {(SCORE_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic REG_TOP_K  = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // Input item kinds
    localparam logic KIND_OFFER  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic [IDXV_W-1:0]         idx;
        logic signed [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        logic insert;   // place the candidate, pushing lower entries down
        logic emit;     // move every entry one place towards the head
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

endpackage

`default_nettype wire

@@ rtl/tks_cell.sv @@
// One place of the sorted list: holds an entry, compares it with the
// candidate and hands entries to its neighbours. Depends on tks_pkg.
`default_nettype none

module tks_cell (
    input  wire              i_clk,
    input  tks_pkg::t_cmd    i_cmd,
    input  wire              i_occupied,
    input  tks_pkg::t_entry  i_cand,
    input  tks_pkg::t_entry  i_prev,
    input  wire              i_prev_ahead,
    input  tks_pkg::t_entry  i_next,
    output tks_pkg::t_entry  o_data,
    output logic             o_ahead
);
    import tks_pkg::*;

    t_entry r_data;
    t_entry n_data;

    // The candidate belongs at or before this place when the place is free
    // or holds a strictly lower score, so ties leave the older entry first.
    assign o_ahead = !i_occupied || (i_cand.score > r_data.score);
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        if (i_cmd.emit) begin
            n_data = i_next;
        end else if (i_cmd.insert && o_ahead) begin
            n_data = i_prev_ahead ? i_prev : i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

@@ rtl/top_k_score_selector.sv @@
// Top level of the top-k score selector: configuration registers, list
// control, the row of tks_cell places and the output register.
// Depends on tks_pkg and tks_cell.
// Candidate: one candidate per cycle while idle.
// Finish: n results (one when the list is empty) leave the output register
// one per cycle while the output is not stalled, the head cell feeding it
// while the row shifts up; no input is taken until the last one is loaded.
// Reset (synchronous): list empty, top_k 16, threshold at the lowest score.
`default_nettype none

module top_k_score_selector (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_kind,
    input  wire  [tks_pkg::IDXV_W-1:0]     i_item_index,
    input  wire  signed [tks_pkg::SCORE_W-1:0] i_score,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [tks_pkg::IDXV_W-1:0]     o_entry_index,
    output logic signed [tks_pkg::SCORE_W-1:0] o_entry_score,
    output logic                           o_entry_valid,
    output logic [tks_pkg::CNT_W-1:0]      o_result_count,
    output logic                           o_last_of_list,
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_index,
    input  wire  [tks_pkg::CFG_W-1:0]      i_cfg_data
);
    import tks_pkg::*;

    logic [TOPK_W-1:0]         r_top_k;
    logic signed [SCORE_W-1:0] r_thresh;
    t_state                    r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          r_rem;
    logic [CNT_W-1:0]          r_n;
    logic                      r_ov;
    t_entry                    r_out;
    logic                      r_out_ev;
    logic [CNT_W-1:0]          r_out_cnt;
    logic                      r_out_last;

    logic [CNT_W-1:0] w_cap;
    logic [CNT_W-1:0] w_eff;
    logic             w_accept;
    logic             w_pass;
    logic             w_out_free;
    logic             w_load;
    t_cmd             w_cmd;
    t_entry           w_cand;
    t_entry           w_cell      [MAX_K];
    t_entry           w_prev      [MAX_K];
    t_entry           w_next      [MAX_K];
    logic [MAX_K-1:0] w_ahead;
    logic [MAX_K-1:0] w_prev_ahead;
    logic [MAX_K-1:0] w_occ;

    // Capacity: top_k of zero acts as one, values past the row saturate.
    always_comb begin
        if (r_top_k == '0) begin
            w_cap = CNT_W'(1);
        end else if (CMP_W'(r_top_k) > CMP_W'(MAX_K)) begin
            w_cap = CNT_W'(MAX_K);
        end else begin
            w_cap = CNT_W'(r_top_k);
        end
        w_eff = (r_cnt > w_cap) ? w_cap : r_cnt;
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pass     = !(r_thresh > i_score);
    assign w_out_free = !r_ov || !i_out_stall;
    assign w_load     = (r_state == ST_EMIT) && w_out_free;

    assign w_cand.idx   = i_item_index;
    assign w_cand.score = i_score;

    assign w_cmd.insert = w_accept && (i_kind == KIND_OFFER) && w_pass;
    assign w_cmd.emit   = w_load && (r_n != '0);

    genvar g;
    generate
        for (g = 0; g < MAX_K; g++) begin : g_cell
            assign w_occ[g] = (CNT_W'(g) < w_eff);
            if (g == 0) begin : g_head
                assign w_prev[g]       = w_cand;
                assign w_prev_ahead[g] = 1'b0;
            end else begin : g_body
                assign w_prev[g]       = w_cell[g-1];
                assign w_prev_ahead[g] = w_ahead[g-1];
            end
            if (g == MAX_K - 1) begin : g_tail
                assign w_next[g] = w_cell[g];
            end else begin : g_mid
                assign w_next[g] = w_cell[g+1];
            end
            tks_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_occupied   (w_occ[g]),
                .i_cand       (w_cand),
                .i_prev       (w_prev[g]),
                .i_prev_ahead (w_prev_ahead[g]),
                .i_next       (w_next[g]),
                .o_data       (w_cell[g]),
                .o_ahead      (w_ahead[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_k  <= TOPK_RESET;
            r_thresh <= THRESH_RESET;
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_rem    <= '0;
            r_n      <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TOP_K:  r_top_k  <= i_cfg_data[TOPK_W-1:0];
                    REG_THRESH: r_thresh <= i_cfg_data[SCORE_W-1:0];
                    default:    r_top_k  <= r_top_k;
                endcase
            end

            if (w_cmd.insert) begin
                r_cnt <= (w_eff < w_cap) ? w_eff + CNT_W'(1) : w_eff;
            end

            if (!w_load && !i_out_stall) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_kind == KIND_FINISH)) begin
                        r_n     <= r_cnt;
                        r_rem   <= r_cnt;
                        r_cnt   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_ov  <= 1'b1;
                        r_rem <= r_rem - CNT_W'(1);
                        if (r_n == '0 || r_rem == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_n == '0) begin
                r_out      <= '0;
                r_out_ev   <= 1'b0;
                r_out_cnt  <= '0;
                r_out_last <= 1'b1;
            end else begin
                r_out      <= w_cell[0];
                r_out_ev   <= 1'b1;
                r_out_cnt  <= r_n;
                r_out_last <= (r_rem == CNT_W'(1));
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_entry_index  = r_out.idx;
    assign o_entry_score  = r_out.score;
    assign o_entry_valid  = r_out_ev;
    assign o_result_count = r_out_cnt;
    assign o_last_of_list = r_out_last;

endmodule

`default_nettype wire

@@ tb/tks_checker.sv @@
// Checker for the top-k score selector: watches the item, result and
// register channels, keeps its own ranked list and compares every result.
// Depends on tks_pkg.
module tks_checker
    import tks_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       i_in_stall,
    input  wire                       i_kind,
    input  wire  [IDXV_W-1:0]         i_item_index,
    input  wire  signed [SCORE_W-1:0] i_score,
    input  wire                       i_out_valid,
    input  wire                       i_out_stall,
    input  wire  [IDXV_W-1:0]         i_entry_index,
    input  wire  signed [SCORE_W-1:0] i_entry_score,
    input  wire                       i_entry_valid,
    input  wire  [CNT_W-1:0]          i_result_count,
    input  wire                       i_last_of_list,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_index,
    input  wire  [CFG_W-1:0]          i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);

    typedef struct packed {
        logic [IDXV_W-1:0]         idx;
        logic signed [SCORE_W-1:0] score;
        logic                      vld;
        logic [CNT_W-1:0]          cnt;
        logic                      last;
    } t_listing;

    t_listing                  listing_q[$];

    logic [IDXV_W-1:0]         kept_idx [MAX_K];
    logic signed [SCORE_W-1:0] kept_sc  [MAX_K];
    int unsigned               kept_cnt;
    logic [TOPK_W-1:0]         topk_reg;
    logic signed [SCORE_W-1:0] thresh_reg;

    function automatic int unsigned list_capacity();
        if (topk_reg == 0) return 1;
        if (topk_reg > MAX_K) return MAX_K;
        return topk_reg;
    endfunction

    // Moves an entry ahead past strictly lower scores, so ties keep their age order.
    function automatic void promote(input int unsigned pos);
        logic [IDXV_W-1:0]         ti;
        logic signed [SCORE_W-1:0] ts;
        int unsigned               p;
        p = pos;
        while (p > 0 && kept_sc[p] > kept_sc[p-1]) begin
            ti            = kept_idx[p];
            ts            = kept_sc[p];
            kept_idx[p]   = kept_idx[p-1];
            kept_sc[p]    = kept_sc[p-1];
            kept_idx[p-1] = ti;
            kept_sc[p-1]  = ts;
            p--;
        end
    endfunction

    function automatic void rank_candidate(input logic [IDXV_W-1:0] idx,
                                           input logic signed [SCORE_W-1:0] sc);
        int unsigned cap;
        cap = list_capacity();
        if (sc < thresh_reg) return;
        // A lowered top_k only trims the list once a candidate gets through.
        if (kept_cnt > cap) kept_cnt = cap;
        if (kept_cnt < cap) begin
            kept_idx[kept_cnt] = idx;
            kept_sc[kept_cnt]  = sc;
            kept_cnt++;
            promote(kept_cnt - 1);
        end else if (sc > kept_sc[cap-1]) begin
            kept_idx[cap-1] = idx;
            kept_sc[cap-1]  = sc;
            promote(cap - 1);
        end
    endfunction

    function automatic void emit_ranked_list();
        t_listing r;
        if (kept_cnt == 0) begin
            r.idx   = '0;
            r.score = '0;
            r.vld   = 1'b0;
            r.cnt   = '0;
            r.last  = 1'b1;
            listing_q.push_back(r);
        end else begin
            for (int unsigned k = 0; k < kept_cnt; k++) begin
                r.idx   = kept_idx[k];
                r.score = kept_sc[k];
                r.vld   = 1'b1;
                r.cnt   = CNT_W'(kept_cnt);
                r.last  = (k + 1 == kept_cnt);
                listing_q.push_back(r);
            end
        end
        kept_cnt = 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tks_checker: %s got %h expected %h at %0t", what, got, want, $time);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_listing want;
        if (!i_rst_n) begin
            topk_reg   = TOPK_RESET;
            thresh_reg = THRESH_RESET;
            kept_cnt   = 0;
            listing_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (listing_q.size() == 0) begin
                    report_mismatch("result with none pending", i_entry_index, '0);
                end else begin
                    want = listing_q.pop_front();
                    if (i_entry_index !== want.idx)
                        report_mismatch("entry_index", i_entry_index, want.idx);
                    if (i_entry_score !== want.score)
                        report_mismatch("entry_score", i_entry_score, want.score);
                    if (i_entry_valid !== want.vld)
                        report_mismatch("entry_valid", i_entry_valid, want.vld);
                    if (i_result_count !== want.cnt)
                        report_mismatch("result_count", i_result_count, want.cnt);
                    if (i_last_of_list !== want.last)
                        report_mismatch("last_of_list", i_last_of_list, want.last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TOP_K) topk_reg = i_cfg_data[TOPK_W-1:0];
                else thresh_reg = i_cfg_data[SCORE_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_FINISH) emit_ranked_list();
                else rank_candidate(i_item_index, i_score);
            end
        end
        o_pending = listing_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the top-k score selector: clock, reset, candidate and
// finish stimulus, register writes, result back-pressure and the verdict.
// Depends on tks_pkg, top_k_score_selector and tks_checker.
module tb_top;
    import tks_pkg::*;

    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 350;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      kind      = KIND_OFFER;
    logic [IDXV_W-1:0]         item_index = '0;
    logic signed [SCORE_W-1:0] score     = '0;
    logic                      out_stall = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic                      cfg_index = REG_TOP_K;
    logic [CFG_W-1:0]          cfg_data  = '0;

    wire                       in_stall;
    wire                       out_valid;
    wire [IDXV_W-1:0]          entry_index;
    wire signed [SCORE_W-1:0]  entry_score;
    wire                       entry_valid;
    wire [CNT_W-1:0]           result_count;
    wire                       last_of_list;

    int                        mismatches;
    int                        pending;

    bit                        quiet    = 1'b0;
    bit                        hold_req = 1'b0;
    int                        items_sent = 0;
    logic [SCORE_W-1:0]        cur_thresh = THRESH_RESET;

    top_k_score_selector i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_item_index   (item_index),
        .i_score        (score),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_entry_index  (entry_index),
        .o_entry_score  (entry_score),
        .o_entry_valid  (entry_valid),
        .o_result_count (result_count),
        .o_last_of_list (last_of_list),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    tks_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_kind         (kind),
        .i_item_index   (item_index),
        .i_score        (score),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_entry_index  (entry_index),
        .i_entry_score  (entry_score),
        .i_entry_valid  (entry_valid),
        .i_result_count (result_count),
        .i_last_of_list (last_of_list),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: random stalls, or a long counted hold-off when asked for.
    initial begin : receiver
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                out_stall <= !quiet && ($urandom_range(99) < 23);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_item(input logic k, input logic [IDXV_W-1:0] idx,
                             input logic [SCORE_W-1:0] sc);
        while (!quiet && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        item_index <= idx;
        score      <= sc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic offer_candidate(input logic [IDXV_W-1:0] idx,
                                   input logic [SCORE_W-1:0] sc);
        push_item(KIND_OFFER, idx, sc);
    endtask

    task automatic finish_search();
        push_item(KIND_FINISH, $urandom(), $urandom());
    endtask

    // Waits until every listed entry has left and the last candidate is absorbed.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_THRESH) cur_thresh = data;
    endtask

    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(4))
            0: return $urandom_range(6) - 3;
            1: return cur_thresh + $urandom_range(4) - 2;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_top_k();
        logic [CFG_W-1:0] k;
        case ($urandom_range(5))
            0: k = 1;
            1: k = 16;
            2: k = 0;
            3: k = $urandom_range(31, 17);
            default: k = $urandom_range(16, 1);
        endcase
        // Bits above the register width carry no meaning.
        if ($urandom_range(3) == 0) k = ($urandom() & ~32'h1F) | k;
        return k;
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return $urandom_range(6) - 3;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        bit pressure;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Finish on an empty list.
        finish_search();

        // Score and index extremes, a tie, default top_k and threshold.
        offer_candidate(32'h0000_0000, 32'h7FFF_FFFF);
        offer_candidate(32'hFFFF_FFFF, 32'h8000_0000);
        offer_candidate(32'h0000_0005, 32'h0000_0000);
        offer_candidate(32'h0000_0006, 32'hFFFF_FFFF);
        offer_candidate(32'h0000_0007, 32'h0000_0000);
        offer_candidate(32'hAAAA_5555, 32'h5555_0000);
        finish_search();
        settle();

        // Full list: an equal score is refused, a higher one replaces the tail.
        write_reg(REG_TOP_K, 2);
        offer_candidate(10, 100);
        offer_candidate(11, 50);
        offer_candidate(12, 50);
        offer_candidate(13, 200);
        finish_search();
        settle();

        // A score equal to the threshold passes, one below it is dropped.
        write_reg(REG_THRESH, 0);
        offer_candidate(20, 32'hFFFF_FFFF);
        offer_candidate(21, 0);
        finish_search();
        settle();

        // top_k lowered to zero under a held list, then a passing candidate.
        write_reg(REG_TOP_K, 16);
        write_reg(REG_THRESH, 32'h8000_0000);
        offer_candidate(30, 1);
        offer_candidate(31, 2);
        offer_candidate(32, 3);
        offer_candidate(33, 4);
        settle();
        write_reg(REG_TOP_K, 0);
        offer_candidate(34, 9);
        finish_search();
        settle();

        // top_k lowered, then finish straight away: all held entries leave.
        write_reg(REG_TOP_K, 16);
        offer_candidate(40, 5);
        offer_candidate(41, 6);
        offer_candidate(42, 5);
        settle();
        write_reg(REG_TOP_K, 1);
        finish_search();

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            phase++;
            quiet    = (phase >= 8 && phase < 12);
            pressure = (phase == 4 || phase == 14);
            if (pressure || $urandom_range(2) != 0) begin
                settle();
                if (pressure) write_reg(REG_TOP_K, 16);
                else if ($urandom_range(1)) write_reg(REG_TOP_K, pick_top_k());
                if (pressure) write_reg(REG_THRESH, 32'h8000_0000);
                else if ($urandom_range(1)) write_reg(REG_THRESH, pick_threshold());
            end
            n = pressure ? 20 : ($urandom_range(4) == 0 ? $urandom_range(40) : $urandom_range(16));
            for (int j = 0; j < n; j++) offer_candidate($urandom(), pick_score());
            if (pressure) begin
                hold_req = 1'b1;
                finish_search();
                // Keep offering while the result side holds off.
                for (int j = 0; j < 6; j++) offer_candidate($urandom(), pick_score());
                finish_search();
            end else if ($urandom_range(9) != 0) begin
                finish_search();
                if ($urandom_range(9) == 0) finish_search();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
